// File: rtl/core/tpi_pkg.sv
// Shared types, constants and saturation helper for the turtle path interpreter.
`default_nettype none

package tpi_pkg;

  // Stack and colour sizing
  localparam int STACK_DEPTH = 16;
  localparam int COLOR_BITS  = 8;
  localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int STK_CW      = $clog2(STACK_DEPTH + 1);

  // Datapath widths
  localparam int CRD_W   = 48;           // Q31.16 coordinate
  localparam int SUM_W   = CRD_W + 5;    // headroom before saturation
  localparam int COEF_W  = 18;           // Q1.16 / Q2.16 register
  localparam int MUL_W   = COEF_W + 1;   // signed operand incl. negated sine / unsigned scale
  localparam int HI_W    = CRD_W - 16;   // upper part of a coordinate
  localparam int LO_W    = 17;           // lower 16 bits, zero extended
  localparam int PHI_W   = MUL_W + HI_W;
  localparam int PLO_W   = MUL_W + LO_W;
  localparam int SHI_W   = PHI_W + 1;
  localparam int SLO_W   = PLO_W + 2;

  localparam logic [7:0] COLOR_MASK = 8'((1 << COLOR_BITS) - 1);

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam logic [2:0] CFG_COS_LEFT    = 3'd0;
  localparam logic [2:0] CFG_SIN_LEFT    = 3'd1;
  localparam logic [2:0] CFG_COS_RIGHT   = 3'd2;
  localparam logic [2:0] CFG_SIN_RIGHT   = 3'd3;
  localparam logic [2:0] CFG_SCALE       = 3'd4;
  localparam logic [2:0] CFG_START_DIR_X = 3'd5;
  localparam logic [2:0] CFG_START_DIR_Y = 3'd6;

  // Request codes
  localparam logic [2:0] REQ_BEGIN      = 3'd0;
  localparam logic [2:0] REQ_LITERAL    = 3'd1;
  localparam logic [2:0] REQ_TURN_LEFT  = 3'd2;
  localparam logic [2:0] REQ_TURN_RIGHT = 3'd3;
  localparam logic [2:0] REQ_PUSH       = 3'd4;
  localparam logic [2:0] REQ_POP        = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_SEGMENT   = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef logic signed [CRD_W-1:0] coord_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       move_flag;
    logic       paint_flag;
    logic [7:0] color_index;
  } in_item_t;

  typedef struct packed {
    coord_t     seg_start_x;
    coord_t     seg_start_y;
    coord_t     seg_end_x;
    coord_t     seg_end_y;
    logic [7:0] seg_color;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    coord_t px;
    coord_t py;
    coord_t dx;
    coord_t dy;
  } stk_entry_t;

  localparam coord_t CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam coord_t CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};

  // Clamp a wide signed sum to the coordinate range
  function automatic coord_t sat_crd(input logic signed [SUM_W-1:0] v);
    coord_t r;
    if (!v[SUM_W-1] && (|v[SUM_W-2:CRD_W-1])) begin
      r = CRD_MAX;
    end else if (v[SUM_W-1] && !(&v[SUM_W-2:CRD_W-1])) begin
      r = CRD_MIN;
    end else begin
      r = v[CRD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/turtle_path_interpreter.sv
// Turtle path interpreter: action stream in, line segments and stack errors out.
//
// Usage
//   in_*  : one turtle action per transfer (begin, literal, turn left/right,
//           push-and-scale, pop).
//   out_* : zero or one result per action - a painted segment, or a stack
//           overflow / underflow report with zeroed coordinates.
//   cfg_* : APB-style register port, registers at byte address 4*i; to be
//           written only while the block is idle; the user must ensure this.
// Sequencing
//   Begin, literal, unknown codes and failing push/pop complete on their transfer.
//   Pop registers the stack memory read, then loads it; in_ready is low meanwhile.
//   Turn and successful push: multiply, sum, round and saturate stages feed
//   the direction registers; in_ready is low meanwhile.
//   A result enters the output queue in the cycle after its action's transfer.
// Reset: synchronous, active low; position, direction, stack count and output
//   queue cleared, registers to defaults. Stack memory is not cleared.
// Back-pressure: a two-entry output queue holds results while out_ready is
//   low; input transfers continue until both entries are occupied.
`default_nettype none

module turtle_path_interpreter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tpi_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [tpi_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [tpi_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [tpi_pkg::CFG_DW-1:0] cfg_prdata,
  output logic               cfg_pready
);
  import tpi_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COEF_W-1:0] cos_left_r, sin_left_r, cos_right_r, sin_right_r, scale_r;
  logic [31:0]       start_dir_x_r, start_dir_y_r;
  logic              cfg_wr;
  logic [2:0]        cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[CFG_AW-1:2];

  always_comb begin
    unique case (cfg_idx)
      CFG_COS_LEFT:    cfg_prdata = CFG_DW'(cos_left_r);
      CFG_SIN_LEFT:    cfg_prdata = CFG_DW'(sin_left_r);
      CFG_COS_RIGHT:   cfg_prdata = CFG_DW'(cos_right_r);
      CFG_SIN_RIGHT:   cfg_prdata = CFG_DW'(sin_right_r);
      CFG_SCALE:       cfg_prdata = CFG_DW'(scale_r);
      CFG_START_DIR_X: cfg_prdata = start_dir_x_r;
      CFG_START_DIR_Y: cfg_prdata = start_dir_y_r;
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Turtle state and control
  // ---------------------------------------------------------------------------
  coord_t            pos_x_r, pos_y_r, dir_x_r, dir_y_r;
  coord_t            pos_x_nxt, pos_y_nxt, dir_x_nxt, dir_y_nxt;
  logic [STK_CW-1:0] stk_cnt_r, stk_cnt_nxt;
  logic              s1_v_r, s2_v_r, pop_v_r;  // multiply stages / pop load pending
  logic [1:0]        q_cnt_r;
  logic              q_wp_r, q_rp_r;

  logic in_acc, is_begin, is_lit, is_turn_l, is_turn_r, is_push, is_pop;
  logic stk_full, stk_empty, push_ok, pop_ok, mul_start;
  logic res_valid, q_push, q_pop;
  out_item_t res_data;

  // Ready depends on registers only: busy stages and queue occupancy
  assign in_ready  = !s1_v_r && !s2_v_r && !pop_v_r && (q_cnt_r != 2'd2);
  assign in_acc    = in_valid && in_ready;

  assign is_begin  = in_data.req_type == REQ_BEGIN;
  assign is_lit    = in_data.req_type == REQ_LITERAL;
  assign is_turn_l = in_data.req_type == REQ_TURN_LEFT;
  assign is_turn_r = in_data.req_type == REQ_TURN_RIGHT;
  assign is_push   = in_data.req_type == REQ_PUSH;
  assign is_pop    = in_data.req_type == REQ_POP;

  assign stk_full  = stk_cnt_r >= STK_CW'(STACK_DEPTH);
  assign stk_empty = stk_cnt_r == '0;
  assign push_ok   = in_acc && is_push && !stk_full;
  assign pop_ok    = in_acc && is_pop && !stk_empty;
  assign mul_start = push_ok || (in_acc && (is_turn_l || is_turn_r));

  // ---------------------------------------------------------------------------
  // Stack memory: one 4-coordinate entry per level, registered read
  // ---------------------------------------------------------------------------
  stk_entry_t        stk_mem [STACK_DEPTH];
  stk_entry_t        stk_rdata_r;
  logic [STK_AW-1:0] stk_waddr, stk_raddr;
  logic [STK_CW-1:0] stk_cnt_dec;

  assign stk_cnt_dec = stk_cnt_r - 1'b1;
  assign stk_waddr   = stk_cnt_r[STK_AW-1:0];
  assign stk_raddr   = stk_cnt_dec[STK_AW-1:0];

  // Push and pop are both single transfers, so a read never meets a write
  // in the same cycle; a pop right after a push reads the freshly written entry.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      stk_mem[stk_waddr] <= '{px: pos_x_r, py: pos_y_r, dx: dir_x_r, dy: dir_y_r};
    end
    if (pop_ok) begin
      stk_rdata_r <= stk_mem[stk_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Direction multiply: n = a*d_x + b*d_y, split into 32-bit high and 16-bit
  // low parts of each coordinate so no multiplier exceeds 19x32.
  // Turn: (c, -s) / (s, c). Push: (scale, 0) / (0, scale).
  // ---------------------------------------------------------------------------
  logic signed [MUL_W-1:0] c_ext, s_ext, s_neg, ax, bx, ay, by;
  logic signed [HI_W-1:0]  hx, hy;
  logic signed [LO_W-1:0]  lx, ly;
  logic signed [PHI_W-1:0] p_axhx_r, p_bxhy_r, p_ayhx_r, p_byhy_r;
  logic signed [PLO_W-1:0] p_axlx_r, p_bxly_r, p_aylx_r, p_byly_r;
  logic signed [SHI_W-1:0] hi_x_r, hi_y_r;
  logic signed [SLO_W-1:0] lo_x_r, lo_y_r;
  coord_t                  mul_x, mul_y;

  localparam logic signed [SLO_W-1:0] LO_RND = SLO_W'(32768);

  assign c_ext = is_turn_l ? MUL_W'($signed(cos_left_r)) : MUL_W'($signed(cos_right_r));
  assign s_ext = is_turn_l ? MUL_W'($signed(sin_left_r)) : MUL_W'($signed(sin_right_r));
  assign s_neg = -s_ext;

  always_comb begin
    if (is_push) begin
      ax = $signed({1'b0, scale_r});
      bx = '0;
      ay = '0;
      by = $signed({1'b0, scale_r});
    end else begin
      ax = c_ext;
      bx = s_neg;
      ay = s_ext;
      by = c_ext;
    end
  end

  assign hx = dir_x_r[CRD_W-1:16];
  assign hy = dir_y_r[CRD_W-1:16];
  assign lx = $signed({1'b0, dir_x_r[15:0]});
  assign ly = $signed({1'b0, dir_y_r[15:0]});

  always_ff @(posedge clk) begin
    // stage 1: partial products
    p_axhx_r <= PHI_W'(ax) * PHI_W'(hx);
    p_bxhy_r <= PHI_W'(bx) * PHI_W'(hy);
    p_ayhx_r <= PHI_W'(ay) * PHI_W'(hx);
    p_byhy_r <= PHI_W'(by) * PHI_W'(hy);
    p_axlx_r <= PLO_W'(ax) * PLO_W'(lx);
    p_bxly_r <= PLO_W'(bx) * PLO_W'(ly);
    p_aylx_r <= PLO_W'(ay) * PLO_W'(lx);
    p_byly_r <= PLO_W'(by) * PLO_W'(ly);
    // stage 2: high sums, low sums with round-half-up
    hi_x_r <= SHI_W'(p_axhx_r) + SHI_W'(p_bxhy_r);
    hi_y_r <= SHI_W'(p_ayhx_r) + SHI_W'(p_byhy_r);
    lo_x_r <= SLO_W'(p_axlx_r) + SLO_W'(p_bxly_r) + LO_RND;
    lo_y_r <= SLO_W'(p_aylx_r) + SLO_W'(p_byly_r) + LO_RND;
  end

  // stage 3: merge low carry-in (floor shift), saturate
  assign mul_x = sat_crd(SUM_W'(hi_x_r) + SUM_W'(lo_x_r >>> 16));
  assign mul_y = sat_crd(SUM_W'(hi_y_r) + SUM_W'(lo_y_r >>> 16));

  // ---------------------------------------------------------------------------
  // State update
  // ---------------------------------------------------------------------------
  coord_t adv_x, adv_y, lit_x, lit_y;

  assign adv_x = sat_crd(SUM_W'(pos_x_r) + SUM_W'(dir_x_r));
  assign adv_y = sat_crd(SUM_W'(pos_y_r) + SUM_W'(dir_y_r));
  assign lit_x = in_data.move_flag ? adv_x : pos_x_r;
  assign lit_y = in_data.move_flag ? adv_y : pos_y_r;

  always_comb begin
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    dir_x_nxt   = dir_x_r;
    dir_y_nxt   = dir_y_r;
    stk_cnt_nxt = stk_cnt_r;
    priority if (s2_v_r) begin
      dir_x_nxt = mul_x;
      dir_y_nxt = mul_y;
    end else if (pop_v_r) begin
      pos_x_nxt = stk_rdata_r.px;
      pos_y_nxt = stk_rdata_r.py;
      dir_x_nxt = stk_rdata_r.dx;
      dir_y_nxt = stk_rdata_r.dy;
    end else if (in_acc && is_begin) begin
      pos_x_nxt   = '0;
      pos_y_nxt   = '0;
      dir_x_nxt   = CRD_W'($signed(start_dir_x_r));
      dir_y_nxt   = CRD_W'($signed(start_dir_y_r));
      stk_cnt_nxt = '0;
    end else if (in_acc && is_lit) begin
      pos_x_nxt = lit_x;
      pos_y_nxt = lit_y;
    end else if (push_ok) begin
      stk_cnt_nxt = stk_cnt_r + 1'b1;
    end else if (pop_ok) begin
      stk_cnt_nxt = stk_cnt_dec;
    end else begin
      // idle or no state change: hold
    end
  end

  // ---------------------------------------------------------------------------
  // Result formation: painted literal, overflow or underflow
  // ---------------------------------------------------------------------------
  always_comb begin
    res_data  = '0;
    res_valid = 1'b0;
    if (is_lit && in_data.paint_flag) begin
      res_valid            = 1'b1;
      res_data.seg_start_x = pos_x_r;
      res_data.seg_start_y = pos_y_r;
      res_data.seg_end_x   = lit_x;
      res_data.seg_end_y   = lit_y;
      res_data.seg_color   = in_data.color_index & COLOR_MASK;
      res_data.status      = ST_SEGMENT;
    end else if (is_push && stk_full) begin
      res_valid       = 1'b1;
      res_data.status = ST_OVERFLOW;
    end else if (is_pop && stk_empty) begin
      res_valid       = 1'b1;
      res_data.status = ST_UNDERFLOW;
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry output queue
  // ---------------------------------------------------------------------------
  out_item_t q_r [2];

  assign q_push    = in_acc && res_valid;
  assign out_valid = q_cnt_r != 2'd0;
  assign q_pop     = out_valid && out_ready;
  assign out_data  = q_r[q_rp_r];

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_r[q_wp_r] <= res_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_left_r    <= COEF_W'(65536);
      sin_left_r    <= '0;
      cos_right_r   <= COEF_W'(65536);
      sin_right_r   <= '0;
      scale_r       <= COEF_W'(65536);
      start_dir_x_r <= 32'd65536;
      start_dir_y_r <= '0;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      dir_x_r       <= '0;
      dir_y_r       <= '0;
      stk_cnt_r     <= '0;
      s1_v_r        <= 1'b0;
      s2_v_r        <= 1'b0;
      pop_v_r       <= 1'b0;
      q_cnt_r       <= '0;
      q_wp_r        <= 1'b0;
      q_rp_r        <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          CFG_COS_LEFT:    cos_left_r    <= cfg_pwdata[COEF_W-1:0];
          CFG_SIN_LEFT:    sin_left_r    <= cfg_pwdata[COEF_W-1:0];
          CFG_COS_RIGHT:   cos_right_r   <= cfg_pwdata[COEF_W-1:0];
          CFG_SIN_RIGHT:   sin_right_r   <= cfg_pwdata[COEF_W-1:0];
          CFG_SCALE:       scale_r       <= cfg_pwdata[COEF_W-1:0];
          CFG_START_DIR_X: start_dir_x_r <= cfg_pwdata;
          CFG_START_DIR_Y: start_dir_y_r <= cfg_pwdata;
          default: ;
        endcase
      end
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
      dir_x_r   <= dir_x_nxt;
      dir_y_r   <= dir_y_nxt;
      stk_cnt_r <= stk_cnt_nxt;
      s1_v_r    <= mul_start;
      s2_v_r    <= s1_v_r;
      pop_v_r   <= pop_ok;
      if (q_push) begin
        q_wp_r <= !q_wp_r;
      end
      if (q_pop) begin
        q_rp_r <= !q_rp_r;
      end
      q_cnt_r <= q_cnt_r + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tpi_chk.sv
// Port-level checker for the turtle path interpreter, bound to the top level.
`default_nettype none

module tpi_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input tpi_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input tpi_pkg::out_item_t out_data
);
  import tpi_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Nothing to deliver straight after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result queue not empty after reset");

  // Turn holds off further transfers while the direction is written back
  a_turn_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_data.req_type == REQ_TURN_LEFT || in_data.req_type == REQ_TURN_RIGHT)
    |=> !in_ready ##1 !in_ready)
    else $error("transfer taken while direction update in flight");

  // Painted literal into an empty queue shows a segment next cycle
  a_seg_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid &&
    in_data.req_type == REQ_LITERAL && in_data.paint_flag
    |=> out_valid && out_data.status == ST_SEGMENT)
    else $error("painted literal gave no segment");

  // Error reports carry zeroed payload
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_SEGMENT
    |-> out_data.seg_start_x == '0 && out_data.seg_start_y == '0 &&
        out_data.seg_end_x == '0 && out_data.seg_end_y == '0 &&
        out_data.seg_color == '0)
    else $error("stack error report with non-zero fields");

endmodule

bind turtle_path_interpreter tpi_chk u_tpi_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
